@@ hdl/gpm_pkg.sv @@
// ----------------------------------------------------------------------------
// gpm_pkg: shared types and constants of the glob pattern matcher
// Operation codes, pattern token kinds, loader states, per-position cell
// record and the ASCII case fold used on both sides of a compare.
// ----------------------------------------------------------------------------
`default_nettype none

package gpm_pkg;

  localparam int MAX_PATTERN_DEF = 64;

  // Operation carried in tuser of each input beat
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_PATH   = 2'd2,
    OP_END    = 2'd3
  } op_t;

  // Pattern syntax bytes
  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] CH_STAR     = 8'h2A;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_BANG     = 8'h21;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // Role of one stored pattern byte in the token parse
  typedef enum logic [2:0] {
    K_LIT,     // literal byte token
    K_ANY,     // '?'
    K_STAR,    // '*'
    K_CSTART,  // '[' opening a class
    K_CBANG,   // '!' right after '[', inverts the class
    K_CBODY,   // listed byte inside a class
    K_CEND     // ']' closing a class
  } kind_t;

  // Loader parse state
  typedef enum logic [1:0] {
    LD_TOKEN,  // next byte starts a token
    LD_OPEN,   // just after '['
    LD_BODY    // inside a class body
  } load_st_t;

  // One pattern position as seen by the automaton
  typedef struct packed {
    logic [7:0] ch;
    kind_t      kind;
    logic       inv;   // class inversion, meaningful on K_CEND
    logic       live;  // below length and not in an unclosed class
  } cell_t;

  // Per-beat command to the automaton
  typedef struct packed {
    logic       restart;
    logic       step;
    logic [7:0] ch;
  } nfa_cmd_t;

  // Fold 'A'..'Z' to lower case when requested
  function automatic logic [7:0] fold_ch(input logic [7:0] c, input logic ci);
    if (ci && (c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) begin
      return c + CASE_OFFSET;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hdl/gpm_pattern_store.sv @@
// ----------------------------------------------------------------------------
// gpm_pattern_store: pattern cells and incremental token parser
// Appends pattern bytes one per beat, tagging each cell with its token role.
// Cells of a class still waiting for its ']' stay pending and are not live.
// ----------------------------------------------------------------------------
`default_nettype none

module gpm_pattern_store #(
  parameter int MAX_PATTERN = gpm_pkg::MAX_PATTERN_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 clear,
  input  logic                                 append,
  input  logic [7:0]                           din,
  output gpm_pkg::cell_t [MAX_PATTERN-1:0]     cells,
  output logic [$clog2(MAX_PATTERN+1)-1:0]     len,
  output logic                                 overflow
);
  import gpm_pkg::*;

  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam int IW = $clog2(MAX_PATTERN);

  logic [7:0]             ch_mem   [MAX_PATTERN];
  kind_t                  kind_mem [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] inv_mem;
  logic [MAX_PATTERN-1:0] pending;

  load_st_t state, state_next;
  logic     inv_open;
  logic     room, wr;
  kind_t    kind_w;
  logic     pend_w, close_w, bang_w;

  assign room = len < LW'(MAX_PATTERN);
  assign wr   = append && room;

  // Parser next state
  always_comb begin
    state_next = state;
    if (clear) begin
      state_next = LD_TOKEN;
    end else if (wr) begin
      case (state)
        LD_TOKEN: begin
          if (din == CH_LBRACKET) state_next = LD_OPEN;
        end
        LD_OPEN: begin
          if (din == CH_RBRACKET) state_next = LD_TOKEN;
          else                    state_next = LD_BODY;
        end
        LD_BODY: begin
          if (din == CH_RBRACKET) state_next = LD_TOKEN;
        end
        default: state_next = LD_TOKEN;
      endcase
    end
  end

  // Parser outputs: role of the byte being appended
  always_comb begin
    kind_w  = K_LIT;
    pend_w  = 1'b0;
    close_w = 1'b0;
    bang_w  = 1'b0;
    case (state)
      LD_TOKEN: begin
        if (din == CH_LBRACKET) begin
          kind_w = K_CSTART;
          pend_w = 1'b1;
        end else if (din == CH_QUESTION) begin
          kind_w = K_ANY;
        end else if (din == CH_STAR) begin
          kind_w = K_STAR;
        end
      end
      LD_OPEN: begin
        if (din == CH_BANG) begin
          kind_w = K_CBANG;
          pend_w = 1'b1;
          bang_w = 1'b1;
        end else if (din == CH_RBRACKET) begin
          // ']' first closes an empty class
          kind_w  = K_CEND;
          close_w = 1'b1;
        end else begin
          kind_w = K_CBODY;
          pend_w = 1'b1;
        end
      end
      LD_BODY: begin
        if (din == CH_RBRACKET) begin
          kind_w  = K_CEND;
          close_w = 1'b1;
        end else begin
          kind_w = K_CBODY;
          pend_w = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= LD_TOKEN;
      len      <= '0;
      overflow <= 1'b0;
      pending  <= '0;
      inv_open <= 1'b0;
    end else begin
      state <= state_next;
      if (clear) begin
        len      <= '0;
        overflow <= 1'b0;
        pending  <= '0;
        inv_open <= 1'b0;
      end else if (append) begin
        if (room) begin
          len <= len + LW'(1);
          if (close_w)     pending <= '0;
          else if (pend_w) pending[len[IW-1:0]] <= 1'b1;
          if (kind_w == K_CSTART) inv_open <= 1'b0;
          else if (bang_w)        inv_open <= 1'b1;
        end else begin
          overflow <= 1'b1;
        end
      end
    end
  end

  // Cell payload, written at the fill position
  always_ff @(posedge clk) begin
    if (wr) begin
      ch_mem[len[IW-1:0]]   <= din;
      kind_mem[len[IW-1:0]] <= kind_w;
      inv_mem[len[IW-1:0]]  <= inv_open;
    end
  end

  // Per-position view for the automaton
  always_comb begin
    for (int q = 0; q < MAX_PATTERN; q++) begin
      cells[q].ch   = ch_mem[q];
      cells[q].kind = kind_mem[q];
      cells[q].inv  = inv_mem[q];
      cells[q].live = (LW'(q) < len) && !pending[q];
    end
  end

  // An open class always leaves pending cells, and only then
  a_pend_state : assert property (@(posedge clk) disable iff (rst)
    (state != LD_TOKEN) == (|pending))
    else $error("parser state and pending cells disagree");

  // Bytes are only dropped once the store is full
  a_ovf_full : assert property (@(posedge clk) disable iff (rst)
    overflow |-> (len == LW'(MAX_PATTERN)))
    else $error("overflow flagged with room left");

endmodule

`default_nettype wire

@@ hdl/gpm_nfa_step.sv @@
// ----------------------------------------------------------------------------
// gpm_nfa_step: active position vector and one-byte transition
// Star closure and class arming run as one carry chain, class membership as
// a second one; the next vector is registered every beat.
// ----------------------------------------------------------------------------
`default_nettype none

module gpm_nfa_step #(
  parameter int MAX_PATTERN = gpm_pkg::MAX_PATTERN_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  gpm_pkg::nfa_cmd_t                    cmd,
  input  logic                                 case_insensitive,
  input  gpm_pkg::cell_t [MAX_PATTERN-1:0]     cells,
  input  logic [$clog2(MAX_PATTERN+1)-1:0]     len,
  output logic                                 accept_now
);
  import gpm_pkg::*;

  localparam int N  = MAX_PATTERN;
  localparam int LW = $clog2(MAX_PATTERN + 1);

  logic [N:0]   active, active_next;
  logic [N:0]   cp, cg, csum, carry, cl, nw, above_len;
  logic [N-1:0] hp, hg, hsum, hcarry;
  logic [N-1:0] lit_hit, stay, fwd;
  logic [7:0]   bf;

  // Transition logic
  always_comb begin
    bf = fold_ch(cmd.ch, case_insensitive);
    for (int q = 0; q < N; q++) begin
      lit_hit[q] = fold_ch(cells[q].ch, case_insensitive) == bf;
      // positions that pass activity on to the next one
      cp[q] = cells[q].live && ((cells[q].kind == K_STAR)  ||
                                (cells[q].kind == K_CSTART) ||
                                (cells[q].kind == K_CBANG)  ||
                                (cells[q].kind == K_CBODY));
      hp[q] = cells[q].live && (cells[q].kind == K_CBODY);
    end
    cp[N] = 1'b0;

    // closure: carry into q = active reached through stars / class interior
    cg    = cp & active;
    csum  = cp + cg;
    carry = csum ^ cp ^ cg;
    cl    = active | carry;

    // class membership: carry into the ']' = some listed byte matched
    hg     = hp & lit_hit;
    hsum   = hp + hg;
    hcarry = hsum ^ hp ^ hg;

    for (int q = 0; q < N; q++) begin
      stay[q] = cells[q].live && (cells[q].kind == K_STAR) && cl[q];
      fwd[q]  = cells[q].live && cl[q] &&
                (((cells[q].kind == K_LIT) && lit_hit[q]) ||
                 (cells[q].kind == K_ANY) ||
                 ((cells[q].kind == K_CEND) && (hcarry[q] ^ cells[q].inv)));
    end
    nw = {1'b0, stay} | {fwd, 1'b0};
  end

  assign accept_now = cl[len];

  // Next active vector
  always_comb begin
    if (cmd.restart)   active_next = (N+1)'(1);
    else if (cmd.step) active_next = nw;
    else               active_next = active;
  end

  always_ff @(posedge clk) begin
    if (rst) active <= (N+1)'(1);
    else     active <= active_next;
  end

  // Positions past the pattern end
  always_comb begin
    for (int q = 0; q <= N; q++) begin
      above_len[q] = LW'(q) > len;
    end
  end

  // Nothing is ever active beyond the end of the pattern
  a_within_len : assert property (@(posedge clk) disable iff (rst)
    (active & above_len) == '0)
    else $error("active position beyond pattern length");

  // A restart leaves only the start position active
  a_restart : assert property (@(posedge clk) disable iff (rst)
    cmd.restart |=> (active == (N+1)'(1)))
    else $error("restart did not reset active positions");

endmodule

`default_nettype wire

@@ hdl/glob_pattern_matcher.sv @@
// ----------------------------------------------------------------------------
// glob_pattern_matcher: streaming glob matcher with bracket classes
// Input beats carry an operation in tuser (clear pattern, append pattern
// byte, path byte, end of path) and a byte in tdata. The pattern is loaded
// byte by byte, then path bytes are streamed; an end-of-path beat yields one
// result beat on m_axis with the match flag and the pattern-too-long flag.
// No other beat yields a result. Loading the pattern restarts any path.
// Timing: every beat passes an input register, then the automaton updates;
// the result register loads on the edge at which its end-of-path beat
// leaves the input register. Throughput is one beat per cycle while no
// end-of-path beat waits on the result register. An end-of-path beat holds
// the input register while the result register is still full and unready;
// s_axis_tready then follows m_axis_tready. Path and pattern beats keep
// flowing while a result waits.
// cfg_wr_en writes the case-insensitive bit; write it only while idle.
// Reset empties the pattern, clears the too-long flag, selects exact case
// and restarts the path.
// ----------------------------------------------------------------------------
`default_nettype none

module glob_pattern_matcher #(
  parameter int MAX_PATTERN = gpm_pkg::MAX_PATTERN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0] s_axis_tuser,   // [1:0] operation
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] matched, [1] pattern_too_long, [7:2] zero
);
  import gpm_pkg::*;

  localparam int LW = $clog2(MAX_PATTERN + 1);

  logic                          case_insensitive;
  logic                          in_vld;
  op_t                           in_op;
  logic [7:0]                    in_byte;
  logic                          out_vld, out_matched, out_too_long;
  logic                          s_fire, adv, fire_end, clear_cmd, append_cmd;
  nfa_cmd_t                      cmd;
  cell_t [MAX_PATTERN-1:0]       cells;
  logic [LW-1:0]                 len;
  logic                          overflow, accept_now;

  // Handshake: only an end-of-path beat facing a full, unready result slot waits
  assign s_axis_tready = !in_vld || adv;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign adv           = in_vld && ((in_op != OP_END) || !out_vld || m_axis_tready);
  assign fire_end      = adv && (in_op == OP_END);
  assign clear_cmd     = adv && (in_op == OP_CLEAR);
  assign append_cmd    = adv && (in_op == OP_APPEND);

  assign cmd.restart = adv && (in_op != OP_PATH);
  assign cmd.step    = adv && (in_op == OP_PATH);
  assign cmd.ch      = in_byte;

  // Config register
  always_ff @(posedge clk) begin
    if (rst)            case_insensitive <= 1'b0;
    else if (cfg_wr_en) case_insensitive <= cfg_wr_data;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst)         in_vld <= 1'b0;
    else if (s_fire) in_vld <= 1'b1;
    else if (adv)    in_vld <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_op   <= op_t'(s_axis_tuser);
      in_byte <= s_axis_tdata;
    end
  end

  gpm_pattern_store #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .clear    (clear_cmd),
    .append   (append_cmd),
    .din      (in_byte),
    .cells    (cells),
    .len      (len),
    .overflow (overflow)
  );

  gpm_nfa_step #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_nfa (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .case_insensitive (case_insensitive),
    .cells            (cells),
    .len              (len),
    .accept_now       (accept_now)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst)                out_vld <= 1'b0;
    else if (fire_end)      out_vld <= 1'b1;
    else if (m_axis_tready) out_vld <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (fire_end) begin
      out_matched  <= accept_now && !overflow;
      out_too_long <= overflow;
    end
  end

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {6'b000000, out_too_long, out_matched};

  // A new result only ever follows an end-of-path beat
  a_result_src : assert property (@(posedge clk) disable iff (rst)
    $rose(out_vld) |-> $past(in_vld && (in_op == OP_END)))
    else $error("result without end-of-path beat");

  // A truncated pattern never reports a match
  a_no_trunc_match : assert property (@(posedge clk) disable iff (rst)
    out_vld |-> !(out_matched && out_too_long))
    else $error("match reported for truncated pattern");

  // A held beat is never lost
  a_hold_beat : assert property (@(posedge clk) disable iff (rst)
    (in_vld && !adv) |=> in_vld)
    else $error("stalled beat dropped from input register");

endmodule

`default_nettype wire
